/* hw/rtl/sfd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared constants and types of the serial frame deframer.
// ----------------------------------------------------------------------------
package sfd_pkg;

    localparam int MAX_FRAME_BYTES_DEF = 128;

    localparam int HDR_BYTES  = 5;
    localparam int CMD_BYTES  = 2;
    localparam int TAIL_BYTES = 2;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_START_BYTE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CRC8_POLY  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CRC8_SEED  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_CRC16_POLY = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_CRC16_SEED = 3'd4;

    localparam logic [7:0]  START_BYTE_RST = 8'hA5;
    localparam logic [7:0]  CRC8_POLY_RST  = 8'h8C;
    localparam logic [7:0]  CRC8_SEED_RST  = 8'hFF;
    localparam logic [15:0] CRC16_POLY_RST = 16'h8408;
    localparam logic [15:0] CRC16_SEED_RST = 16'hFFFF;

    localparam logic [2:0] VERDICT_NONE     = 3'd0;
    localparam logic [2:0] VERDICT_GOOD     = 3'd1;
    localparam logic [2:0] VERDICT_BAD_LEN  = 3'd2;
    localparam logic [2:0] VERDICT_BAD_HCRC = 3'd3;
    localparam logic [2:0] VERDICT_BAD_FCRC = 3'd4;

    typedef struct packed {
        logic [7:0]  start_byte;
        logic [7:0]  crc8_poly;
        logic [7:0]  crc8_seed;
        logic [15:0] crc16_poly;
        logic [15:0] crc16_seed;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  verdict;
        logic [15:0] command_id;
        logic [6:0]  payload_length;
        logic [7:0]  sequence_res;
    } frame_res_t;

    typedef struct packed {
        logic       is_read;
        logic       rd_ok;
        frame_res_t frm;
    } res_t;

endpackage
`default_nettype wire

/* hw/rtl/sfd_store.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_store
// Frame byte store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sfd_store #(
    parameter int DEPTH = sfd_pkg::MAX_FRAME_BYTES_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [7:0]               wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [7:0]               rd_data_reg
);
    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/sfd_parser.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_parser
// Frame parser: header/body sequencing, CRC8 and CRC16, store writes.
// ----------------------------------------------------------------------------
module sfd_parser #(
    parameter int MAX_FRAME_BYTES = sfd_pkg::MAX_FRAME_BYTES_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               byte_accept,
    input  wire logic [7:0]                         rx_byte,
    input  wire sfd_pkg::cfg_t                      cfg,
    output logic                                    wr_en,
    output logic [$clog2(MAX_FRAME_BYTES)-1:0]      wr_addr,
    output logic [7:0]                              wr_data,
    output sfd_pkg::frame_res_t                     frm
);
    import sfd_pkg::*;

    localparam int AW = $clog2(MAX_FRAME_BYTES);
    localparam int CW = $clog2(MAX_FRAME_BYTES + 1);
    localparam logic [CW-1:0] MAX_C       = CW'(MAX_FRAME_BYTES);
    localparam logic [15:0]   LEN_LIMIT   = 16'(MAX_FRAME_BYTES - HDR_BYTES - CMD_BYTES
                                                - TAIL_BYTES);
    localparam logic [CW-1:0] CRC_END     = CW'(HDR_BYTES + CMD_BYTES);
    localparam logic [CW-1:0] LAST_OFS    = CW'(HDR_BYTES + CMD_BYTES + TAIL_BYTES - 1);
    localparam logic [CW-1:0] CMD_LO_POS  = CW'(HDR_BYTES);
    localparam logic [CW-1:0] CMD_HI_POS  = CW'(HDR_BYTES + 1);

    typedef enum logic [5:0] {
        PH_HUNT   = 6'b000001,
        PH_LEN_LO = 6'b000010,
        PH_LEN_HI = 6'b000100,
        PH_SEQ    = 6'b001000,
        PH_HCRC   = 6'b010000,
        PH_BODY   = 6'b100000
    } phase_t;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b,
                                             input logic [7:0] poly);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b,
                                               input logic [15:0] poly);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
        end
        return c;
    endfunction

    phase_t          phase_reg,  phase_next;
    logic [CW-1:0]   count_reg,  count_next;
    logic [AW-1:0]   plen_reg,   plen_next;
    logic [7:0]      hcrc_reg,   hcrc_next;
    logic [15:0]     fcrc_reg,   fcrc_next;
    logic [7:0]      len_lo_reg, len_lo_next;
    logic [7:0]      seq_reg,    seq_next;
    logic [15:0]     cmd_reg,    cmd_next;
    logic [7:0]      prev_reg,   prev_next;

    logic            put;
    logic            base_zero;
    logic [CW-1:0]   wr_base;
    logic [7:0]      hcrc_upd;
    logic [15:0]     fcrc_upd;
    logic [15:0]     len_rx;
    logic [CW-1:0]   plen_ext;

    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        plen_next   = plen_reg;
        hcrc_next   = hcrc_reg;
        fcrc_next   = fcrc_reg;
        len_lo_next = len_lo_reg;
        seq_next    = seq_reg;
        cmd_next    = cmd_reg;
        prev_next   = prev_reg;
        frm         = '0;
        put         = 1'b0;
        base_zero   = 1'b0;
        wr_en       = 1'b0;
        wr_data     = rx_byte;
        hcrc_upd    = crc8_byte(hcrc_reg, rx_byte, cfg.crc8_poly);
        fcrc_upd    = crc16_byte(fcrc_reg, rx_byte, cfg.crc16_poly);
        len_rx      = {rx_byte, len_lo_reg};
        plen_ext    = CW'(plen_reg);

        if (byte_accept)
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    if (rx_byte == cfg.start_byte)
                    begin
                        put        = 1'b1;
                        base_zero  = 1'b1;
                        hcrc_next  = crc8_byte(cfg.crc8_seed, rx_byte, cfg.crc8_poly);
                        fcrc_next  = crc16_byte(cfg.crc16_seed, rx_byte, cfg.crc16_poly);
                        phase_next = PH_LEN_LO;
                    end
                end
                PH_LEN_LO:
                begin
                    put         = 1'b1;
                    hcrc_next   = hcrc_upd;
                    fcrc_next   = fcrc_upd;
                    len_lo_next = rx_byte;
                    phase_next  = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    put       = 1'b1;
                    hcrc_next = hcrc_upd;
                    fcrc_next = fcrc_upd;
                    if (len_rx >= LEN_LIMIT)
                    begin
                        frm.verdict = VERDICT_BAD_LEN;
                        phase_next  = PH_HUNT;
                    end
                    else
                    begin
                        plen_next  = AW'(len_rx);
                        phase_next = PH_SEQ;
                    end
                end
                PH_SEQ:
                begin
                    put        = 1'b1;
                    hcrc_next  = hcrc_upd;
                    fcrc_next  = fcrc_upd;
                    seq_next   = rx_byte;
                    phase_next = PH_HCRC;
                end
                PH_HCRC:
                begin
                    put       = 1'b1;
                    fcrc_next = fcrc_upd;
                    if (hcrc_reg == rx_byte)
                    begin
                        phase_next = PH_BODY;
                    end
                    else
                    begin
                        frm.verdict        = VERDICT_BAD_HCRC;
                        frm.payload_length = 7'(plen_reg);
                        frm.sequence_res   = seq_reg;
                        phase_next         = PH_HUNT;
                    end
                end
                PH_BODY:
                begin
                    put       = 1'b1;
                    prev_next = rx_byte;
                    if (count_reg < CRC_END + plen_ext)
                    begin
                        fcrc_next = fcrc_upd;
                    end
                    if (count_reg == CMD_LO_POS)
                    begin
                        cmd_next[7:0] = rx_byte;
                    end
                    if (count_reg == CMD_HI_POS)
                    begin
                        cmd_next[15:8] = rx_byte;
                    end
                    if (count_reg >= LAST_OFS + plen_ext)
                    begin
                        frm.payload_length = 7'(plen_reg);
                        frm.sequence_res   = seq_reg;
                        if ({rx_byte, prev_reg} == fcrc_reg)
                        begin
                            frm.verdict    = VERDICT_GOOD;
                            frm.command_id = cmd_reg;
                        end
                        else
                        begin
                            frm.verdict = VERDICT_BAD_FCRC;
                        end
                        phase_next = PH_HUNT;
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end

        wr_base = base_zero ? '0 : count_reg;
        wr_addr = wr_base[AW-1:0];
        if (put && (wr_base < MAX_C))
        begin
            wr_en      = 1'b1;
            count_next = wr_base + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            count_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        plen_reg   <= plen_next;
        hcrc_reg   <= hcrc_next;
        fcrc_reg   <= fcrc_next;
        len_lo_reg <= len_lo_next;
        seq_reg    <= seq_next;
        cmd_reg    <= cmd_next;
        prev_reg   <= prev_next;
    end

endmodule
`default_nettype wire

/* hw/rtl/sfd_out_stage.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_out_stage
// Store-read stage and output register with stall handling.
// ----------------------------------------------------------------------------
module sfd_out_stage (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          load,
    input  wire sfd_pkg::res_t res_in,
    input  wire logic [7:0]    rd_data,
    output logic               in_stall,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic [2:0]         verdict,
    output logic [15:0]        command_id,
    output logic [6:0]         payload_length,
    output logic [7:0]         sequence_res,
    output logic [7:0]         read_byte
);
    import sfd_pkg::*;

    logic       s1_valid_reg, s1_valid_next;
    res_t       s1_res_reg;
    logic       out_valid_reg, out_valid_next;
    frame_res_t out_frm_reg;
    logic [7:0] out_rd_reg;
    logic       s1_adv;

    always_comb
    begin
        s1_adv   = s1_valid_reg && (!out_valid_reg || !out_stall);
        in_stall = s1_valid_reg && out_valid_reg && out_stall;

        s1_valid_next = s1_valid_reg;
        if (load)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_res_reg <= res_in;
        end
        if (s1_adv)
        begin
            out_frm_reg <= s1_res_reg.frm;
            out_rd_reg  <= (s1_res_reg.is_read && s1_res_reg.rd_ok) ? rd_data : 8'h00;
        end
    end

    assign out_valid      = out_valid_reg;
    assign verdict        = out_frm_reg.verdict;
    assign command_id     = out_frm_reg.command_id;
    assign payload_length = out_frm_reg.payload_length;
    assign sequence_res   = out_frm_reg.sequence_res;
    assign read_byte      = out_rd_reg;

endmodule
`default_nettype wire

/* hw/rtl/serial_frame_deframer_crc8_crc16_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// serial_frame_deframer_crc8_crc16_core
// Start-byte / length / CRC8 / CRC16 serial frame deframer with frame store.
// ----------------------------------------------------------------------------
// One request is taken per clock unless stalled. A byte request is parsed in
// the cycle it is accepted (byte-wide CRC8 and CRC16 logic) and written to the
// frame store; a read request reads the store at read_index. Every request
// gives one result, held in the read stage and the store's registered read
// port, then in the output register. in_stall rises only when both the read
// stage and the output register hold a result and out_stall is high. The frame
// store is not cleared at reset; reading a position never written returns an
// undefined byte, and positions at or beyond MAX_FRAME_BYTES read as zero.
// Make configuration writes only while no request is in flight; not enforced.
module serial_frame_deframer_crc8_crc16_core #(
    parameter int MAX_FRAME_BYTES = sfd_pkg::MAX_FRAME_BYTES_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write,
    input  wire logic [sfd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [sfd_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic                            req_type,
    input  wire logic [7:0]                      rx_byte,
    input  wire logic [6:0]                      read_index,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [2:0]                           verdict,
    output logic [15:0]                          command_id,
    output logic [6:0]                           payload_length,
    output logic [7:0]                           sequence_res,
    output logic [7:0]                           read_byte
);
    import sfd_pkg::*;

    localparam int AW = $clog2(MAX_FRAME_BYTES);

    cfg_t       cfg_reg, cfg_next;
    logic       in_accept;
    logic       byte_accept;
    logic       rd_en;
    logic       wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0] wr_data;
    logic [7:0] rd_data;
    frame_res_t frm;
    res_t       res;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_START_BYTE: cfg_next.start_byte = cfg_data[7:0];
                CFG_CRC8_POLY:  cfg_next.crc8_poly  = cfg_data[7:0];
                CFG_CRC8_SEED:  cfg_next.crc8_seed  = cfg_data[7:0];
                CFG_CRC16_POLY: cfg_next.crc16_poly = cfg_data;
                CFG_CRC16_SEED: cfg_next.crc16_seed = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_byte <= START_BYTE_RST;
            cfg_reg.crc8_poly  <= CRC8_POLY_RST;
            cfg_reg.crc8_seed  <= CRC8_SEED_RST;
            cfg_reg.crc16_poly <= CRC16_POLY_RST;
            cfg_reg.crc16_seed <= CRC16_SEED_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign in_accept   = in_valid && !in_stall;
    assign byte_accept = in_accept && !req_type;
    assign rd_en       = in_accept && req_type;

    sfd_parser #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_accept (byte_accept),
        .rx_byte     (rx_byte),
        .cfg         (cfg_reg),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .frm         (frm)
    );

    sfd_store #(
        .DEPTH (MAX_FRAME_BYTES)
    ) u_store (
        .clk         (clk),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .rd_en       (rd_en),
        .rd_addr     (AW'(read_index)),
        .rd_data_reg (rd_data)
    );

    always_comb
    begin
        res.is_read = req_type;
        res.rd_ok   = 32'(read_index) < 32'(MAX_FRAME_BYTES);
        res.frm     = frm;
    end

    sfd_out_stage u_out (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (in_accept),
        .res_in         (res),
        .rd_data        (rd_data),
        .in_stall       (in_stall),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .verdict        (verdict),
        .command_id     (command_id),
        .payload_length (payload_length),
        .sequence_res   (sequence_res),
        .read_byte      (read_byte)
    );

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while output side can move");

    a_read_has_no_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && read_byte != 8'h00) |-> (verdict == VERDICT_NONE))
        else $error("read result carries a frame verdict");

    a_cmd_only_good: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && command_id != 16'h0000) |-> (verdict == VERDICT_GOOD))
        else $error("command id on a frame that is not good");

endmodule
`default_nettype wire

/* verif/tb_serial_frame_deframer_crc8_crc16_core.sv */
// ----------------------------------------------------------------------------
// tb_serial_frame_deframer_crc8_crc16_core
// Self-checking bench for the serial frame deframer. A frame model tracks
// the parser, both CRCs and the frame store. Directed frames come first,
// then register extremes, a mid-frame register change and a receiver hold.
// A long random run follows: mostly well-formed frames, some corrupted,
// truncated or stray bytes, with store reads mixed in. Idle cycles are
// random on both sides.
// ----------------------------------------------------------------------------
module tb_serial_frame_deframer_crc8_crc16_core;

    timeunit 1ns;
    timeprecision 1ps;

    import sfd_pkg::*;

    localparam int MAX_FRAME      = MAX_FRAME_BYTES_DEF;
    localparam int OVERHEAD       = HDR_BYTES + CMD_BYTES + TAIL_BYTES;
    localparam int LEN_LIMIT      = MAX_FRAME - OVERHEAD;
    localparam int RANDOM_ITEMS   = 950;
    localparam int CFG_EVERY      = 175;
    localparam int HOLD_CYCLES    = 120;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 6;

    localparam logic [CFG_INDEX_W-1:0] CFG_NO_REG = 3'd5;

    typedef enum logic [2:0] {
        ST_SEEK,
        ST_LEN_LO,
        ST_LEN_HI,
        ST_SEQ,
        ST_HDR_CRC,
        ST_BODY
    } parse_state_t;

    typedef enum int {
        FR_GOOD,
        FR_BAD_HCRC,
        FR_BAD_FCRC,
        FR_BAD_LEN,
        FR_CUT
    } frame_kind_t;

    typedef struct {
        logic [2:0]  verdict;
        logic [15:0] command_id;
        logic [6:0]  payload_length;
        logic [7:0]  sequence_res;
        logic [7:0]  read_byte;
    } deframe_res_t;

    logic                   clk;
    logic                   rst_n          = 1'b0;
    logic                   cfg_write      = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index      = '0;
    logic [CFG_DATA_W-1:0]  cfg_data       = '0;
    logic                   in_valid       = 1'b0;
    logic                   in_stall;
    logic                   req_type       = 1'b0;
    logic [7:0]             rx_byte        = '0;
    logic [6:0]             read_index     = '0;
    logic                   out_valid;
    logic                   out_stall      = 1'b0;
    logic [2:0]             verdict;
    logic [15:0]            command_id;
    logic [6:0]             payload_length;
    logic [7:0]             sequence_res;
    logic [7:0]             read_byte;

    // frame model state
    cfg_t         cfg;
    parse_state_t parse_state;
    int           mem_count;
    logic [6:0]   frame_plen;
    logic [7:0]   hdr_crc;
    logic [15:0]  body_crc;
    logic [7:0]   frame_mem [MAX_FRAME];
    bit           mem_written [MAX_FRAME];

    deframe_res_t pending_results [$];

    bit tx_gaps = 1'b1;
    bit rx_gaps = 1'b1;
    int rx_hold = 0;
    int errors = 0;
    int items_sent = 0;
    int results_checked = 0;
    int reads_checked = 0;
    int cfg_writes = 0;
    int cfg_sets = 0;
    int verdict_seen [8];
    int quiet_cycles = 0;

    serial_frame_deframer_crc8_crc16_core u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .req_type       (req_type),
        .rx_byte        (rx_byte),
        .read_index     (read_index),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .verdict        (verdict),
        .command_id     (command_id),
        .payload_length (payload_length),
        .sequence_res   (sequence_res),
        .read_byte      (read_byte)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // frame model
    // ------------------------------------------------------------------
    function automatic logic [7:0] crc8_byte(logic [7:0] c, logic [7:0] d);
        logic [7:0] x;
        x = c ^ d;
        for (int i = 0; i < 8; i++)
        begin
            x = x[0] ? ((x >> 1) ^ cfg.crc8_poly) : (x >> 1);
        end
        return x;
    endfunction

    function automatic logic [15:0] crc16_byte(logic [15:0] c, logic [7:0] d);
        logic [15:0] x;
        x = c ^ {8'h00, d};
        for (int i = 0; i < 8; i++)
        begin
            x = x[0] ? ((x >> 1) ^ cfg.crc16_poly) : (x >> 1);
        end
        return x;
    endfunction

    function automatic void mem_put(logic [7:0] b);
        if (mem_count < MAX_FRAME)
        begin
            frame_mem[mem_count] = b;
            mem_written[mem_count] = 1'b1;
            mem_count++;
        end
    endfunction

    function automatic void reset_model();
        cfg.start_byte = START_BYTE_RST;
        cfg.crc8_poly = CRC8_POLY_RST;
        cfg.crc8_seed = CRC8_SEED_RST;
        cfg.crc16_poly = CRC16_POLY_RST;
        cfg.crc16_seed = CRC16_SEED_RST;
        parse_state = ST_SEEK;
        mem_count = 0;
        frame_plen = '0;
        hdr_crc = cfg.crc8_seed;
        body_crc = cfg.crc16_seed;
        foreach (mem_written[i])
        begin
            mem_written[i] = 1'b0;
            frame_mem[i] = '0;
        end
    endfunction

    function automatic deframe_res_t predict_deframe(bit is_read, logic [7:0] b,
                                                     logic [6:0] idx);
        deframe_res_t r;
        int unsigned  flen;
        logic [15:0]  hdr_len;
        logic [15:0]  rx_crc;
        r = '{default: '0};
        if (is_read)
        begin
            r.read_byte = frame_mem[idx];
        end
        else
        begin
            case (parse_state)
                ST_SEEK:
                begin
                    if (b == cfg.start_byte)
                    begin
                        mem_count = 0;
                        mem_put(b);
                        hdr_crc = crc8_byte(cfg.crc8_seed, b);
                        body_crc = crc16_byte(cfg.crc16_seed, b);
                        parse_state = ST_LEN_LO;
                    end
                end
                ST_LEN_LO, ST_SEQ:
                begin
                    mem_put(b);
                    hdr_crc = crc8_byte(hdr_crc, b);
                    body_crc = crc16_byte(body_crc, b);
                    parse_state = (parse_state == ST_LEN_LO) ? ST_LEN_HI : ST_HDR_CRC;
                end
                ST_LEN_HI:
                begin
                    mem_put(b);
                    hdr_crc = crc8_byte(hdr_crc, b);
                    body_crc = crc16_byte(body_crc, b);
                    hdr_len = {frame_mem[2], frame_mem[1]};
                    if (hdr_len >= LEN_LIMIT)
                    begin
                        r.verdict = VERDICT_BAD_LEN;
                        parse_state = ST_SEEK;
                    end
                    else
                    begin
                        frame_plen = hdr_len[6:0];
                        parse_state = ST_SEQ;
                    end
                end
                ST_HDR_CRC:
                begin
                    mem_put(b);
                    body_crc = crc16_byte(body_crc, b);
                    if (hdr_crc == b)
                    begin
                        parse_state = ST_BODY;
                    end
                    else
                    begin
                        r.verdict = VERDICT_BAD_HCRC;
                        r.payload_length = frame_plen;
                        r.sequence_res = frame_mem[3];
                        parse_state = ST_SEEK;
                    end
                end
                ST_BODY:
                begin
                    flen = OVERHEAD + frame_plen;
                    // the two CRC bytes themselves are not covered
                    if (mem_count + TAIL_BYTES < flen)
                        body_crc = crc16_byte(body_crc, b);
                    mem_put(b);
                    if (mem_count >= flen)
                    begin
                        rx_crc = {frame_mem[flen-1], frame_mem[flen-2]};
                        r.payload_length = frame_plen;
                        r.sequence_res = frame_mem[3];
                        if (rx_crc == body_crc)
                        begin
                            r.verdict = VERDICT_GOOD;
                            r.command_id = {frame_mem[6], frame_mem[5]};
                        end
                        else
                        begin
                            r.verdict = VERDICT_BAD_FCRC;
                        end
                        parse_state = ST_SEEK;
                    end
                end
                default:
                begin
                    parse_state = ST_SEEK;
                end
            endcase
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic send_req(input bit is_read, input logic [7:0] b, input logic [6:0] idx);
        bit counted;
        while (tx_gaps && $urandom_range(0, 99) < 22)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= is_read;
        rx_byte <= b;
        read_index <= idx;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        counted = is_read || parse_state != ST_SEEK || b == cfg.start_byte;
        if (counted)
            items_sent++;
        if (is_read)
            reads_checked++;
        pending_results.push_back(predict_deframe(is_read, b, idx));
    endtask

    // reads only touch store entries that some frame has written
    task automatic send_read();
        logic [6:0] idx;
        if (mem_written[0])
        begin
            do
                idx = 7'($urandom_range(0, MAX_FRAME - 1));
            while (!mem_written[idx]);
            send_req(1'b1, 8'($urandom_range(0, 255)), idx);
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_writes++;
    endtask

    // block must be idle; upper data bits of byte-wide registers are junk
    task automatic apply_config(input cfg_t nc, input bit add_unused);
        logic [15:0] junk;
        junk = 16'($urandom_range(0, 65535));
        write_reg(CFG_START_BYTE, {junk[15:8], nc.start_byte});
        write_reg(CFG_CRC8_POLY, {junk[7:0], nc.crc8_poly});
        write_reg(CFG_CRC8_SEED, {junk[11:4], nc.crc8_seed});
        write_reg(CFG_CRC16_POLY, nc.crc16_poly);
        write_reg(CFG_CRC16_SEED, nc.crc16_seed);
        if (add_unused)
            write_reg(CFG_NO_REG + 3'($urandom_range(0, 2)), junk);
        cfg_write <= 1'b0;
        cfg = nc;
        cfg_sets++;
    endtask

    function automatic logic [15:0] pick_value(int bits);
        logic [15:0] mask;
        int          r;
        mask = 16'((32'd1 << bits) - 1);
        r = $urandom_range(0, 7);
        if (r == 0)
            return '0;
        else if (r == 1)
            return mask;
        else
            return 16'($urandom_range(0, 65535)) & mask;
    endfunction

    function automatic cfg_t random_cfg();
        cfg_t nc;
        nc.start_byte = 8'(pick_value(8));
        nc.crc8_poly = 8'(pick_value(8));
        nc.crc8_seed = 8'(pick_value(8));
        nc.crc16_poly = pick_value(16);
        nc.crc16_seed = pick_value(16);
        return nc;
    endfunction

    function automatic int random_plen();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(0, 12);
        else if (r < 95)
            return $urandom_range(13, 60);
        else if (r < 99)
            return $urandom_range(100, LEN_LIMIT - 2);
        else
            return LEN_LIMIT - 1;
    endfunction

    // len_field is the payload length, or the oversize length for FR_BAD_LEN
    task automatic build_frame(input frame_kind_t kind, input int len_field,
                               ref logic [7:0] fb[$]);
        logic [15:0] len16;
        logic [7:0]  h;
        logic [15:0] f;
        fb.delete();
        len16 = 16'(len_field);
        fb.push_back(cfg.start_byte);
        fb.push_back(len16[7:0]);
        fb.push_back(len16[15:8]);
        if (kind != FR_BAD_LEN)
        begin
            fb.push_back(8'($urandom_range(0, 255)));
            h = cfg.crc8_seed;
            foreach (fb[i])
                h = crc8_byte(h, fb[i]);
            if (kind == FR_BAD_HCRC)
                h ^= 8'(1 << $urandom_range(0, 7));
            fb.push_back(h);
            if (kind != FR_BAD_HCRC)
            begin
                repeat (CMD_BYTES + len_field)
                    fb.push_back(8'($urandom_range(0, 255)));
                f = cfg.crc16_seed;
                foreach (fb[i])
                    f = crc16_byte(f, fb[i]);
                if (kind == FR_BAD_FCRC)
                    f ^= 16'(1 << $urandom_range(0, 15));
                fb.push_back(f[7:0]);
                fb.push_back(f[15:8]);
                if (kind == FR_CUT)
                    fb = fb[0:$urandom_range(0, fb.size() - 2)];
            end
        end
    endtask

    task automatic send_frame(ref logic [7:0] fb[$], input int from, input int upto,
                              input int read_pct);
        for (int i = from; i < upto; i++)
        begin
            if ($urandom_range(0, 99) < read_pct)
                send_read();
            send_req(1'b0, fb[i], 7'($urandom_range(0, 127)));
        end
    endtask

    // ------------------------------------------------------------------
    // receiver and checker
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        errors++;
        $display("[%0t] MISMATCH result %0d: %s", $realtime, results_checked, msg);
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    always @(posedge clk)
    begin : rx_side
        deframe_res_t want;
        if (rst_n && out_valid === 1'b1 && out_stall == 1'b0)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("result with no request pending");
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("verdict", 16'(verdict), 16'(want.verdict));
                check_field("command_id", command_id, want.command_id);
                check_field("payload_length", 16'(payload_length),
                            16'(want.payload_length));
                check_field("sequence_res", 16'(sequence_res), 16'(want.sequence_res));
                check_field("read_byte", 16'(read_byte), 16'(want.read_byte));
                verdict_seen[want.verdict]++;
            end
            results_checked++;
        end
        if (rx_hold > 0)
        begin
            out_stall <= 1'b1;
            rx_hold--;
        end
        else
        begin
            out_stall <= rx_gaps && ($urandom_range(0, 99) < 22);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
            $display("tb_serial_frame_deframer_crc8_crc16_core: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_good_frame();
        logic [7:0] fb[$];
        build_frame(FR_GOOD, 0, fb);
        send_frame(fb, 0, fb.size(), 0);
    endtask

    task automatic test_header_rejects();
        logic [7:0] fb[$];
        build_frame(FR_BAD_LEN, LEN_LIMIT, fb);
        send_frame(fb, 0, fb.size(), 0);
        build_frame(FR_BAD_HCRC, 4, fb);
        send_frame(fb, 0, fb.size(), 0);
    endtask

    task automatic test_frame_crc_error();
        logic [7:0] fb[$];
        build_frame(FR_BAD_FCRC, 0, fb);
        send_frame(fb, 0, fb.size(), 0);
    endtask

    task automatic test_store_reads();
        int top;
        top = 0;
        foreach (mem_written[i])
            if (mem_written[i])
                top = i;
        send_req(1'b1, 8'h00, 7'd0);
        send_req(1'b1, 8'hFF, 7'(top));
    endtask

    task automatic test_config_extremes();
        logic [7:0] fb[$];
        cfg_t       nc;
        nc = '0;
        wait_idle();
        apply_config(nc, 1'b1);
        build_frame(FR_GOOD, 2, fb);
        send_frame(fb, 0, fb.size(), 0);
        nc = '1;
        wait_idle();
        apply_config(nc, 1'b0);
        build_frame(FR_GOOD, 2, fb);
        send_frame(fb, 0, fb.size(), 0);
        nc = '{START_BYTE_RST, CRC8_POLY_RST, CRC8_SEED_RST, CRC16_POLY_RST, CRC16_SEED_RST};
        wait_idle();
        apply_config(nc, 1'b0);
    endtask

    // polynomials switch at once, seeds only at the next start byte
    task automatic test_midframe_config(input int plen);
        logic [7:0] fb[$];
        int         cut;
        build_frame(FR_GOOD, plen, fb);
        cut = $urandom_range(1, fb.size() - 1);
        send_frame(fb, 0, cut, 0);
        wait_idle();
        apply_config(random_cfg(), 1'b0);
        send_frame(fb, cut, fb.size(), 0);
    endtask

    task automatic test_backpressure();
        logic [7:0] fb[$];
        wait_idle();
        rx_hold = HOLD_CYCLES;
        build_frame(FR_GOOD, 20, fb);
        send_frame(fb, 0, fb.size(), 0);
        wait_idle();
    endtask

    task automatic test_random_traffic();
        logic [7:0]  fb[$];
        frame_kind_t kind;
        int          base;
        int          next_cfg;
        int          pick;
        int          k;
        int          len_field;
        base = items_sent;
        next_cfg = base + CFG_EVERY;
        while (items_sent - base < RANDOM_ITEMS)
        begin
            tx_gaps = !(items_sent - base >= 400 && items_sent - base < 650);
            rx_gaps = tx_gaps;
            if (items_sent >= next_cfg)
            begin
                wait_idle();
                apply_config(random_cfg(), $urandom_range(0, 3) == 0);
                next_cfg += CFG_EVERY;
            end
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                repeat ($urandom_range(1, 5))
                    send_req(1'b0, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
            end
            else if (pick < 16)
            begin
                repeat ($urandom_range(1, 4))
                    send_read();
            end
            else if (pick < 18)
            begin
                test_midframe_config(random_plen());
            end
            else
            begin
                k = $urandom_range(0, 99);
                kind = k < 66 ? FR_GOOD : k < 76 ? FR_BAD_HCRC : k < 86 ? FR_BAD_FCRC :
                       k < 94 ? FR_BAD_LEN : FR_CUT;
                len_field = random_plen();
                if (kind == FR_BAD_LEN)
                begin
                    k = $urandom_range(0, 3);
                    len_field = k == 0 ? LEN_LIMIT : k == 1 ? 65535 :
                                $urandom_range(LEN_LIMIT, 65535);
                end
                build_frame(kind, len_field, fb);
                send_frame(fb, 0, fb.size(), 6);
            end
        end
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
    endtask

    initial
    begin
        reset_model();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        test_good_frame();
        test_header_rejects();
        test_frame_crc_error();
        test_store_reads();
        test_config_extremes();
        test_midframe_config(3);
        test_backpressure();
        test_random_traffic();
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("%0d results: %0d good, %0d length rejects, %0d header CRC, %0d frame CRC",
                 results_checked, verdict_seen[VERDICT_GOOD], verdict_seen[VERDICT_BAD_LEN],
                 verdict_seen[VERDICT_BAD_HCRC], verdict_seen[VERDICT_BAD_FCRC]);
        $display("%0d store reads, %0d register writes over %0d settings, %0d mismatches",
                 reads_checked, cfg_writes, cfg_sets, errors);
        if (errors == 0 && pending_results.size() == 0)
            $display("tb_serial_frame_deframer_crc8_crc16_core: clean");
        else
            $display("tb_serial_frame_deframer_crc8_crc16_core: errors");
        $finish;
    end

endmodule
